### hdl/detection_vote_tracker_core_defines.svh
// Assertion macros shared by the detection vote tracker RTL.
`ifndef DETECTION_VOTE_TRACKER_CORE_DEFINES_SVH
`define DETECTION_VOTE_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvt assertion failed");

// Next-cycle implication, disabled while in reset.
`define DVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvt assertion failed");

`endif

### hdl/dvt_pkg.sv
// Shared types and constants for the detection vote tracker.
package dvt_pkg;

  localparam int CLASS_COUNT_DEF  = 8;
  localparam int VOTE_WIDTH_DEF   = 16;
  localparam int CAMERA_COUNT_DEF = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  CONF_MIN_RST  = 8'd50;
  localparam logic [15:0] WIN_MAX_RST   = 16'hFFFF;
  localparam logic [15:0] FRESH_MS_RST  = 16'd500;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_MIN  = 3'd0,
    REG_POS_REQ   = 3'd1,
    REG_WIN_MIN_X = 3'd2,
    REG_WIN_MAX_X = 3'd3,
    REG_WIN_MIN_Y = 3'd4,
    REG_WIN_MAX_Y = 3'd5,
    REG_FRESH_MS  = 3'd6
  } reg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;  // capture the input transaction
    logic prep;   // update per-camera fields, reset the class walk
    logic step;   // one class of the vote walk
    logic load;   // load the result register
  } dvt_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;
  } dvt_sts_t;

endpackage

### hdl/dvt_ctrl.sv
// Sequencer for the detection vote tracker: handshakes and walk control.
`include "detection_vote_tracker_core_defines.svh"

module dvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dvt_pkg::dvt_sts_t sts_i,
  output dvt_pkg::dvt_ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl_o.latch = in_valid_i && in_ready_o;
    ctl_o.prep  = (state_q == S_PREP);
    ctl_o.step  = (state_q == S_WALK);
    ctl_o.load  = load;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: state_d = S_WALK;
      S_WALK: begin
        if (sts_i.walk_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DVT_ASSERT_NXT(a_accept_prep, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_PREP)
  `DVT_ASSERT_NXT(a_walk_done, clk_i, rst_ni, (state_q == S_WALK) && sts_i.walk_last, state_q == S_DONE)
  `DVT_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE))
  `DVT_ASSERT_NXT(a_done_free, clk_i, rst_ni, (state_q == S_DONE) && !out_valid_q, out_valid_q && (state_q == S_IDLE))

endmodule

### hdl/dvt_datapath.sv
// Datapath: config registers, per-camera state, vote counters, class walk, result register.
module dvt_datapath #(
  parameter int CLASS_COUNT  = dvt_pkg::CLASS_COUNT_DEF,
  parameter int VOTE_WIDTH   = dvt_pkg::VOTE_WIDTH_DEF,
  parameter int CAMERA_COUNT = dvt_pkg::CAMERA_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dvt_pkg::dvt_ctl_t              ctl_i,
  output dvt_pkg::dvt_sts_t              sts_o,
  input  logic                           cfg_we_i,
  input  logic [dvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dvt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [1:0]                     command_i,
  input  logic                           camera_i,
  input  logic                           frame_ok_i,
  input  logic [7:0]                     class_mask_i,
  input  logic [7:0]                     frame_confidence_i,
  input  logic [15:0]                    frame_x_i,
  input  logic [15:0]                    frame_y_i,
  input  logic [7:0]                     frame_seq_i,
  input  logic                           count_enable_i,
  input  logic [31:0]                    now_ms_i,
  output logic [7:0]                     accepted_mask_o,
  output logic [3:0]                     best_class_o,
  output logic [15:0]                    lead_votes_o,
  output logic [7:0]                     confidence_o,
  output logic [15:0]                    pos_x_o,
  output logic [15:0]                    pos_y_o,
  output logic [7:0]                     seq_o,
  output logic                           frame_present_o,
  output logic                           fresh_o,
  output logic                           conf_pass_o,
  output logic                           window_pass_o,
  output logic                           reliable_o
);

  localparam int CAM_W = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1;
  localparam int CLS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = '1;
  localparam logic [CLS_W-1:0] CLS_LAST = CLS_W'(CLASS_COUNT - 1);

  // configuration
  logic [7:0]  conf_min_q;
  logic        pos_req_q;
  logic [15:0] win_min_x_q, win_max_x_q, win_min_y_q, win_max_y_q;
  logic [15:0] fresh_ms_q;

  // latched transaction
  logic [1:0]  cmd_q;
  logic        cam_q, ok_q, cnt_en_q;
  logic [7:0]  mask_q, fconf_q, fseq_q;
  logic [15:0] fx_q, fy_q;
  logic [31:0] now_q;

  // per-camera state
  logic [CLASS_COUNT-1:0] flags_q [CAMERA_COUNT];
  logic [VOTE_WIDTH-1:0]  votes_q [CAMERA_COUNT][CLASS_COUNT];
  logic [7:0]             sconf_q [CAMERA_COUNT];
  logic [15:0]            sx_q    [CAMERA_COUNT];
  logic [15:0]            sy_q    [CAMERA_COUNT];
  logic [7:0]             sseq_q  [CAMERA_COUNT];
  logic [31:0]            rx_q    [CAMERA_COUNT];
  logic [CAMERA_COUNT-1:0] seen_q;

  // class walk
  logic [CLS_W-1:0]      cls_q;
  logic [VOTE_WIDTH-1:0] best_q;
  logic [3:0]            best_idx_q;

  logic                   cam_ok;
  logic [CAM_W-1:0]       cam_rd;
  logic                   is_frame, is_clear;
  logic                   frm_pass;
  logic [CLASS_COUNT-1:0] flags_nxt;
  logic [VOTE_WIDTH-1:0]  cur_v, frm_v, new_v;
  logic [31:0]            age, best_ext;
  logic                   fresh, conf_ok, pos_ok;

  function automatic logic in_win(input logic req, input logic [15:0] px,
                                  input logic [15:0] py, input logic [15:0] x_lo,
                                  input logic [15:0] x_hi, input logic [15:0] y_lo,
                                  input logic [15:0] y_hi);
    in_win = !req || ((px >= x_lo) && (px <= x_hi) && (py >= y_lo) && (py <= y_hi));
  endfunction

  assign cam_ok   = ({31'd0, cam_q} < 32'(CAMERA_COUNT));
  assign cam_rd   = cam_ok ? CAM_W'(cam_q) : '0;
  assign is_frame = (cmd_q == dvt_pkg::CMD_FRAME);
  assign is_clear = (cmd_q == dvt_pkg::CMD_CLEAR);

  // contract check: mask bits above the class range still count as nonzero
  assign frm_pass  = (mask_q != 8'd0) && (fconf_q >= conf_min_q) &&
                     in_win(pos_req_q, fx_q, fy_q, win_min_x_q, win_max_x_q,
                            win_min_y_q, win_max_y_q);
  assign flags_nxt = (ok_q && frm_pass) ? mask_q[CLASS_COUNT-1:0] : '0;

  always_comb begin
    cur_v = votes_q[cam_rd][cls_q];
    frm_v = cur_v;
    if (!ok_q || !frm_pass || !cnt_en_q) begin
      frm_v = '0;
    end else if (flags_nxt[cls_q] && (cur_v != VOTE_MAX)) begin
      frm_v = cur_v + VOTE_WIDTH'(1);
    end
    new_v = cur_v;
    if (is_clear) begin
      new_v = '0;
    end else if (is_frame && cam_ok) begin
      new_v = frm_v;
    end
  end

  assign sts_o.walk_last = (cls_q == CLS_LAST);

  assign age      = now_q - rx_q[cam_rd];
  assign fresh    = seen_q[cam_rd] && (age <= {16'd0, fresh_ms_q});
  assign conf_ok  = (sconf_q[cam_rd] >= conf_min_q);
  assign pos_ok   = in_win(pos_req_q, sx_q[cam_rd], sy_q[cam_rd], win_min_x_q,
                           win_max_x_q, win_min_y_q, win_max_y_q);
  assign best_ext = 32'(best_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_min_q  <= dvt_pkg::CONF_MIN_RST;
      pos_req_q   <= 1'b0;
      win_min_x_q <= '0;
      win_max_x_q <= dvt_pkg::WIN_MAX_RST;
      win_min_y_q <= '0;
      win_max_y_q <= dvt_pkg::WIN_MAX_RST;
      fresh_ms_q  <= dvt_pkg::FRESH_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dvt_pkg::REG_CONF_MIN:  conf_min_q  <= cfg_wdata_i[7:0];
        dvt_pkg::REG_POS_REQ:   pos_req_q   <= cfg_wdata_i[0];
        dvt_pkg::REG_WIN_MIN_X: win_min_x_q <= cfg_wdata_i;
        dvt_pkg::REG_WIN_MAX_X: win_max_x_q <= cfg_wdata_i;
        dvt_pkg::REG_WIN_MIN_Y: win_min_y_q <= cfg_wdata_i;
        dvt_pkg::REG_WIN_MAX_Y: win_max_y_q <= cfg_wdata_i;
        dvt_pkg::REG_FRESH_MS:  fresh_ms_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q    <= command_i;
      cam_q    <= camera_i;
      ok_q     <= frame_ok_i;
      mask_q   <= class_mask_i;
      fconf_q  <= frame_confidence_i;
      fx_q     <= frame_x_i;
      fy_q     <= frame_y_i;
      fseq_q   <= frame_seq_i;
      cnt_en_q <= count_enable_i;
      now_q    <= now_ms_i;
    end
  end

  // per-camera state and vote counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CAMERA_COUNT; c++) begin
        flags_q[c] <= '0;
        sconf_q[c] <= '0;
        sx_q[c]    <= '0;
        sy_q[c]    <= '0;
        sseq_q[c]  <= '0;
        rx_q[c]    <= '0;
        for (int k = 0; k < CLASS_COUNT; k++) begin
          votes_q[c][k] <= '0;
        end
      end
      seen_q     <= '0;
      cls_q      <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else begin
      if (ctl_i.prep) begin
        cls_q      <= '0;
        best_q     <= '0;
        best_idx_q <= '0;
        if (is_frame && cam_ok) begin
          flags_q[cam_rd] <= flags_nxt;
          seen_q[cam_rd]  <= ok_q;
          if (ok_q) begin
            sconf_q[cam_rd] <= fconf_q;
            sx_q[cam_rd]    <= fx_q;
            sy_q[cam_rd]    <= fy_q;
            sseq_q[cam_rd]  <= fseq_q;
            rx_q[cam_rd]    <= now_q;
          end else begin
            // unparsed frame: arrival time is kept
            sconf_q[cam_rd] <= '0;
            sx_q[cam_rd]    <= '0;
            sy_q[cam_rd]    <= '0;
            sseq_q[cam_rd]  <= '0;
          end
        end
      end
      if (ctl_i.step) begin
        for (int c = 0; c < CAMERA_COUNT; c++) begin
          if (is_clear || (cam_ok && (CAM_W'(c) == cam_rd))) begin
            votes_q[c][cls_q] <= new_v;
          end
        end
        // strict compare keeps the lowest class on ties
        if (cam_ok && (new_v > best_q)) begin
          best_q     <= new_v;
          best_idx_q <= 4'(cls_q) + 4'd1;
        end
        cls_q <= sts_o.walk_last ? '0 : cls_q + CLS_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      if (cam_ok) begin
        accepted_mask_o <= 8'(flags_q[cam_rd]);
        best_class_o    <= best_idx_q;
        lead_votes_o    <= best_ext[15:0];
        confidence_o    <= sconf_q[cam_rd];
        pos_x_o         <= sx_q[cam_rd];
        pos_y_o         <= sy_q[cam_rd];
        seq_o           <= sseq_q[cam_rd];
        frame_present_o <= seen_q[cam_rd];
        fresh_o         <= fresh;
        conf_pass_o     <= conf_ok;
        window_pass_o   <= pos_ok;
        reliable_o      <= fresh && conf_ok && pos_ok && (flags_q[cam_rd] != '0);
      end else begin
        accepted_mask_o <= '0;
        best_class_o    <= '0;
        lead_votes_o    <= '0;
        confidence_o    <= '0;
        pos_x_o         <= '0;
        pos_y_o         <= '0;
        seq_o           <= '0;
        frame_present_o <= 1'b0;
        fresh_o         <= 1'b0;
        conf_pass_o     <= 1'b0;
        window_pass_o   <= 1'b0;
        reliable_o      <= 1'b0;
      end
    end
  end

endmodule

### hdl/detection_vote_tracker_core.sv
// Top level of the detection vote tracker: controller plus datapath.
// Per-camera detection tracker with one saturating vote counter per class. Each input
// transaction (frame, query or clear-all) returns one observation of the selected camera.
// After the accepting edge the controller first updates the camera's stored fields (S_PREP),
// then walks the vote counters one class per cycle (S_WALK), both updating each counter and
// tracking the leading class, and then loads the result register (S_DONE). The next
// transaction is accepted in the cycle after the load at the earliest, so the block takes no
// new transaction before it has loaded the last result. in_ready_o is high only between
// transactions, and a finished result waits in S_DONE while the previous result has not been
// taken by out_ready_i. Configuration registers may be written at any time the block is idle
// and come up at their defaults after reset; reset also clears per-camera state, vote
// counters and walk registers, but not the latched transaction or the result register.
module detection_vote_tracker_core #(
  parameter int CLASS_COUNT  = dvt_pkg::CLASS_COUNT_DEF,
  parameter int VOTE_WIDTH   = dvt_pkg::VOTE_WIDTH_DEF,
  parameter int CAMERA_COUNT = dvt_pkg::CAMERA_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dvt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     command_i,
  input  logic                           camera_i,
  input  logic                           frame_ok_i,
  input  logic [7:0]                     class_mask_i,
  input  logic [7:0]                     frame_confidence_i,
  input  logic [15:0]                    frame_x_i,
  input  logic [15:0]                    frame_y_i,
  input  logic [7:0]                     frame_seq_i,
  input  logic                           count_enable_i,
  input  logic [31:0]                    now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     accepted_mask_o,
  output logic [3:0]                     best_class_o,
  output logic [15:0]                    lead_votes_o,
  output logic [7:0]                     confidence_o,
  output logic [15:0]                    pos_x_o,
  output logic [15:0]                    pos_y_o,
  output logic [7:0]                     seq_o,
  output logic                           frame_present_o,
  output logic                           fresh_o,
  output logic                           conf_pass_o,
  output logic                           window_pass_o,
  output logic                           reliable_o
);

  dvt_pkg::dvt_ctl_t ctl;
  dvt_pkg::dvt_sts_t sts;

  dvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dvt_datapath #(
    .CLASS_COUNT  (CLASS_COUNT),
    .VOTE_WIDTH   (VOTE_WIDTH),
    .CAMERA_COUNT (CAMERA_COUNT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .command_i          (command_i),
    .camera_i           (camera_i),
    .frame_ok_i         (frame_ok_i),
    .class_mask_i       (class_mask_i),
    .frame_confidence_i (frame_confidence_i),
    .frame_x_i          (frame_x_i),
    .frame_y_i          (frame_y_i),
    .frame_seq_i        (frame_seq_i),
    .count_enable_i     (count_enable_i),
    .now_ms_i           (now_ms_i),
    .accepted_mask_o    (accepted_mask_o),
    .best_class_o       (best_class_o),
    .lead_votes_o       (lead_votes_o),
    .confidence_o       (confidence_o),
    .pos_x_o            (pos_x_o),
    .pos_y_o            (pos_y_o),
    .seq_o              (seq_o),
    .frame_present_o    (frame_present_o),
    .fresh_o            (fresh_o),
    .conf_pass_o        (conf_pass_o),
    .window_pass_o      (window_pass_o),
    .reliable_o         (reliable_o)
  );

endmodule
